// ----- src/cwg_pkg.sv -----
// Shared types, codes and reset values for the command watchdog governor.
package cwg_pkg;

    localparam int unsigned ValW   = 16;
    localparam int unsigned LimW   = 15;
    localparam int unsigned AgeW   = 16;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDatW = 16;

    // Item kinds carried in the func field
    localparam logic FUNC_CMD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_ACCEL_LIMIT = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_STEER_LIMIT = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_STOP_EPS    = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_TIMEOUT     = 2'd3;

    localparam logic [LimW-1:0] ACCEL_LIMIT_RST = 15'd512;
    localparam logic [LimW-1:0] STEER_LIMIT_RST = 15'd128;
    localparam logic [LimW-1:0] STOP_EPS_RST    = 15'd3;
    localparam logic [AgeW-1:0] TIMEOUT_RST     = 16'd500;

    typedef struct packed {
        logic                   func;
        logic signed [ValW-1:0] cmd_accel;
        logic signed [ValW-1:0] cmd_steer;
        logic signed [ValW-1:0] velocity;
        logic [AgeW-1:0]        command_age;
    } t_in;

    typedef struct packed {
        logic signed [ValW-1:0] accel_out;
        logic signed [ValW-1:0] steer_out;
        logic                   accel_limited;
        logic                   steer_limited;
        logic                   engaged;
        logic                   engaged_pulse;
        logic                   recovered_pulse;
        logic                   snap_to_zero;
    } t_out;

    typedef struct packed {
        logic [LimW-1:0] accel_limit;
        logic [LimW-1:0] steer_limit;
        logic [LimW-1:0] stop_speed_eps;
        logic [AgeW-1:0] timeout_ms;
    } t_cfg;

endpackage

// ----- src/cwg_cfg_regs.sv -----
// Configuration register file for the command watchdog governor.
module cwg_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cwg_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [cwg_pkg::CfgDatW-1:0]     i_cfg_data,
    output cwg_pkg::t_cfg                   o_cfg
);

    cwg_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_limit    <= cwg_pkg::ACCEL_LIMIT_RST;
            r_cfg.steer_limit    <= cwg_pkg::STEER_LIMIT_RST;
            r_cfg.stop_speed_eps <= cwg_pkg::STOP_EPS_RST;
            r_cfg.timeout_ms     <= cwg_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cwg_pkg::CFG_ACCEL_LIMIT: begin
                    r_cfg.accel_limit <= i_cfg_data[cwg_pkg::LimW-1:0];
                end
                cwg_pkg::CFG_STEER_LIMIT: begin
                    r_cfg.steer_limit <= i_cfg_data[cwg_pkg::LimW-1:0];
                end
                cwg_pkg::CFG_STOP_EPS: begin
                    r_cfg.stop_speed_eps <= i_cfg_data[cwg_pkg::LimW-1:0];
                end
                cwg_pkg::CFG_TIMEOUT: begin
                    r_cfg.timeout_ms <= i_cfg_data[cwg_pkg::AgeW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/cwg_gov.sv -----
// Governor datapath: clamp, watchdog state and actuation resolve for one item.
module cwg_gov (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  cwg_pkg::t_in   i_item,
    input  cwg_pkg::t_cfg  i_cfg,
    output cwg_pkg::t_out  o_res,
    output logic           o_engaged
);

    logic                                r_engaged;
    logic signed [cwg_pkg::ValW-1:0]     r_held_accel;
    logic signed [cwg_pkg::ValW-1:0]     r_held_steer;
    logic                                n_engaged;

    logic signed [cwg_pkg::ValW:0] accel_ext, steer_ext, vel_ext;
    logic signed [cwg_pkg::ValW:0] alim_ext, slim_ext;
    logic signed [cwg_pkg::ValW-1:0] accel_bounded, steer_clamped, brake;
    logic        accel_hit, steer_hit;
    logic [cwg_pkg::ValW:0] speed;
    logic        should, slow;

    assign accel_ext = {i_item.cmd_accel[cwg_pkg::ValW-1], i_item.cmd_accel};
    assign steer_ext = {i_item.cmd_steer[cwg_pkg::ValW-1], i_item.cmd_steer};
    assign vel_ext   = {i_item.velocity[cwg_pkg::ValW-1], i_item.velocity};
    assign alim_ext  = signed'({2'b00, i_cfg.accel_limit});
    assign slim_ext  = signed'({2'b00, i_cfg.steer_limit});

    // Symmetric clamp; a value sitting exactly on the limit is not a hit
    always_comb begin
        accel_hit     = 1'b1;
        accel_bounded = alim_ext[cwg_pkg::ValW-1:0];
        if (accel_ext > alim_ext) begin
            accel_bounded = alim_ext[cwg_pkg::ValW-1:0];
        end else if (accel_ext < -alim_ext) begin
            accel_bounded = 16'(-alim_ext);
        end else begin
            accel_hit     = 1'b0;
            accel_bounded = i_item.cmd_accel;
        end
    end

    always_comb begin
        steer_hit     = 1'b1;
        steer_clamped = slim_ext[cwg_pkg::ValW-1:0];
        if (steer_ext > slim_ext) begin
            steer_clamped = slim_ext[cwg_pkg::ValW-1:0];
        end else if (steer_ext < -slim_ext) begin
            steer_clamped = 16'(-slim_ext);
        end else begin
            steer_hit     = 1'b0;
            steer_clamped = i_item.cmd_steer;
        end
    end

    assign speed  = vel_ext[cwg_pkg::ValW] ? unsigned'(-vel_ext) : unsigned'(vel_ext);
    assign slow   = speed < {2'b00, i_cfg.stop_speed_eps};
    assign should = i_item.command_age > i_cfg.timeout_ms;
    // Brake against the direction of travel; zero velocity brakes positive
    assign brake  = (vel_ext > 17'sd0) ? 16'(-alim_ext) : alim_ext[cwg_pkg::ValW-1:0];

    always_comb begin
        o_res     = '0;
        n_engaged = r_engaged;
        if (i_item.func == cwg_pkg::FUNC_CMD) begin
            n_engaged               = 1'b0;
            o_res.accel_out         = accel_bounded;
            o_res.steer_out         = steer_clamped;
            o_res.accel_limited     = accel_hit;
            o_res.steer_limited     = steer_hit;
            o_res.recovered_pulse   = r_engaged;
        end else begin
            n_engaged             = should;
            o_res.engaged_pulse   = should && !r_engaged;
            o_res.recovered_pulse = !should && r_engaged;
            o_res.engaged         = should;
            o_res.steer_out       = r_held_steer;
            if (!should) begin
                o_res.accel_out = r_held_accel;
            end else if (slow) begin
                o_res.snap_to_zero = 1'b1;
            end else begin
                o_res.accel_out = brake;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_engaged    <= 1'b0;
            r_held_accel <= '0;
            r_held_steer <= '0;
        end else if (i_adv) begin
            r_engaged <= n_engaged;
            if (i_item.func == cwg_pkg::FUNC_CMD) begin
                r_held_accel <= accel_bounded;
                r_held_steer <= steer_clamped;
            end
        end
    end

    assign o_engaged = r_engaged;

endmodule

// ----- src/command_watchdog_governor.sv -----
// Each beat passes the input register, then the result register. One item per cycle
// while results drain; a new beat can enter the input register while a result waits.
// Each item is resolved by one pass of clamp/compare/select logic between the registers.
// Reset (synchronous, active low): both stages empty, watchdog disengaged, held
// command zero, registers at accel_limit 512, steer_limit 128, eps 3, timeout 500.
module command_watchdog_governor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  cwg_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output cwg_pkg::t_out               o_out_data,
    input  logic                        i_cfg_we,
    input  logic [cwg_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [cwg_pkg::CfgDatW-1:0] i_cfg_data
);

    logic          r_in_valid;
    cwg_pkg::t_in  r_in;
    logic          r_out_valid;
    cwg_pkg::t_out r_out;
    cwg_pkg::t_cfg cfg;
    cwg_pkg::t_out res;
    logic          adv;
    logic          wd_engaged;

    cwg_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    cwg_gov u_gov (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .o_res     (res),
        .o_engaged (wd_engaged)
    );

    // Advance the held item when the result slot is free or being drained
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The waiting result always reflects the current watchdog state
    a_engaged_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.engaged == wd_engaged))
        else $error("result engaged flag out of step with watchdog state");

    a_pulse_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.engaged_pulse && r_out.recovered_pulse))
        else $error("engage and recover pulse on the same beat");

    a_snap_engaged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.snap_to_zero) |-> (r_out.engaged && r_out.accel_out == '0))
        else $error("snap without engaged watchdog or nonzero accel");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result beat changed");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the command watchdog governor: directed, register and random traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic                         i_clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    cwg_pkg::t_in                 in_data = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    cwg_pkg::t_out                out_data;
    logic                         cfg_we = 1'b0;
    logic [cwg_pkg::CfgIdxW-1:0]  cfg_idx = '0;
    logic [cwg_pkg::CfgDatW-1:0]  cfg_data = '0;

    // Local copy of the governor state and registers
    cwg_pkg::t_cfg       gov_cfg;
    logic                guard_on;
    int                  kept_accel;
    int                  kept_steer;

    cwg_pkg::t_out       pending_actuation[$];
    int                  snd_idle_pct = 8;
    int                  rcv_idle_pct = 62;
    int                  n_errors = 0;
    int                  n_items = 0;
    int                  n_checked = 0;
    int                  n_engage = 0;
    int                  n_recover = 0;
    int                  n_snap = 0;
    int                  n_clamp = 0;
    int                  n_settings = 0;

    command_watchdog_governor u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Resolve one item against the local state and advance that state
    function automatic cwg_pkg::t_out resolve_actuation(cwg_pkg::t_in it);
        cwg_pkg::t_out r;
        int   v;
        int   lim;
        int   spd;
        logic over;
        r = '0;
        if (it.func == cwg_pkg::FUNC_CMD) begin
            v   = $signed(it.cmd_accel);
            lim = int'(gov_cfg.accel_limit);
            if (v > lim) begin
                v = lim;
                r.accel_limited = 1'b1;
            end else if (v < -lim) begin
                v = -lim;
                r.accel_limited = 1'b1;
            end
            kept_accel = v;
            v   = $signed(it.cmd_steer);
            lim = int'(gov_cfg.steer_limit);
            if (v > lim) begin
                v = lim;
                r.steer_limited = 1'b1;
            end else if (v < -lim) begin
                v = -lim;
                r.steer_limited = 1'b1;
            end
            kept_steer = v;
            r.recovered_pulse = guard_on;
            guard_on    = 1'b0;
            r.accel_out = 16'(kept_accel);
            r.steer_out = 16'(kept_steer);
        end else begin
            over = it.command_age > gov_cfg.timeout_ms;
            if (over && !guard_on) begin
                guard_on = 1'b1;
                r.engaged_pulse = 1'b1;
            end else if (!over && guard_on) begin
                guard_on = 1'b0;
                r.recovered_pulse = 1'b1;
            end
            r.steer_out = 16'(kept_steer);
            if (guard_on) begin
                v   = $signed(it.velocity);
                spd = (v < 0) ? -v : v;
                if (spd < int'(gov_cfg.stop_speed_eps)) begin
                    r.accel_out    = '0;
                    r.snap_to_zero = 1'b1;
                end else if (v > 0) begin
                    r.accel_out = 16'(-int'(gov_cfg.accel_limit));
                end else begin
                    r.accel_out = 16'(int'(gov_cfg.accel_limit));
                end
            end else begin
                r.accel_out = 16'(kept_accel);
            end
        end
        r.engaged = guard_on;
        return r;
    endfunction

    // Drive one beat, wait for the handshake, then queue its expected result
    task automatic send_item(cwg_pkg::t_in it);
        cwg_pkg::t_out r;
        while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
        r = resolve_actuation(it);
        pending_actuation.push_back(r);
        n_items++;
        n_engage  += r.engaged_pulse;
        n_recover += r.recovered_pulse;
        n_snap    += r.snap_to_zero;
        n_clamp   += r.accel_limited | r.steer_limited;
    endtask

    task automatic send_cmd(int a, int s);
        cwg_pkg::t_in it;
        it.func        = cwg_pkg::FUNC_CMD;
        it.cmd_accel   = 16'(a);
        it.cmd_steer   = 16'(s);
        it.velocity    = 16'($urandom);
        it.command_age = 16'($urandom);
        send_item(it);
    endtask

    task automatic send_tick(int vel, int age);
        cwg_pkg::t_in it;
        it.func        = cwg_pkg::FUNC_TICK;
        it.cmd_accel   = 16'($urandom);
        it.cmd_steer   = 16'($urandom);
        it.velocity    = 16'(vel);
        it.command_age = 16'(age);
        send_item(it);
    endtask

    // Hold off the sender until every result is back and the pipe is empty
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_actuation.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [cwg_pkg::CfgIdxW-1:0] idx,
                             logic [cwg_pkg::CfgDatW-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            cwg_pkg::CFG_ACCEL_LIMIT: gov_cfg.accel_limit    = val[cwg_pkg::LimW-1:0];
            cwg_pkg::CFG_STEER_LIMIT: gov_cfg.steer_limit    = val[cwg_pkg::LimW-1:0];
            cwg_pkg::CFG_STOP_EPS:    gov_cfg.stop_speed_eps = val[cwg_pkg::LimW-1:0];
            cwg_pkg::CFG_TIMEOUT:     gov_cfg.timeout_ms     = val[cwg_pkg::AgeW-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(int a, int s, int e, int t);
        wait_quiet();
        write_reg(cwg_pkg::CFG_ACCEL_LIMIT, 16'(a));
        write_reg(cwg_pkg::CFG_STEER_LIMIT, 16'(s));
        write_reg(cwg_pkg::CFG_STOP_EPS, 16'(e));
        write_reg(cwg_pkg::CFG_TIMEOUT, 16'(t));
        n_settings++;
    endtask

    // Random values, values within +/-lim and values clustered around +/-lim, the 16-bit extremes and zero
    function automatic logic signed [cwg_pkg::ValW-1:0] near_limit(int lim);
        int v;
        case ($urandom_range(5))
            0: v = $urandom;
            1: v = lim + $urandom_range(4) - 2;
            2: v = -lim + $urandom_range(4) - 2;
            3: v = $urandom_range(1) ? 32767 : -32768;
            4: v = $urandom_range(16) - 8;
            default: v = $urandom_range(2 * lim) - lim;
        endcase
        return 16'(v);
    endfunction

    function automatic logic [cwg_pkg::AgeW-1:0] pick_age();
        int t;
        int a;
        t = int'(gov_cfg.timeout_ms);
        case ($urandom_range(4))
            0: a = $urandom_range(65535);
            1: a = t + $urandom_range(4) - 2;
            2: a = $urandom_range(t, 0);
            3: a = $urandom_range(65535, t);
            default: a = $urandom_range(1) ? 65535 : 0;
        endcase
        if (a < 0) a = 0;
        if (a > 65535) a = 65535;
        return 16'(a);
    endfunction

    function automatic cwg_pkg::t_in random_item();
        cwg_pkg::t_in it;
        it.func        = ($urandom_range(99) < 35) ? cwg_pkg::FUNC_CMD : cwg_pkg::FUNC_TICK;
        it.cmd_accel   = near_limit(int'(gov_cfg.accel_limit));
        it.cmd_steer   = near_limit(int'(gov_cfg.steer_limit));
        it.velocity    = near_limit(int'(gov_cfg.stop_speed_eps));
        it.command_age = pick_age();
        return it;
    endfunction

    task automatic check_field(string fname, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            n_errors++;
            if (n_errors <= 40)
                $display("%0t ns: %s mismatch: expected %h, got %h", $time, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin : chk_beat
        cwg_pkg::t_out want;
        if (rst_n && out_valid && out_ready) begin
            n_checked++;
            if (pending_actuation.size() == 0) begin
                n_errors++;
                $display("%0t ns: result beat with nothing expected, got %h", $time, out_data);
            end else begin
                want = pending_actuation.pop_front();
                check_field("accel_out", want.accel_out, out_data.accel_out);
                check_field("steer_out", want.steer_out, out_data.steer_out);
                check_field("accel_limited", want.accel_limited, out_data.accel_limited);
                check_field("steer_limited", want.steer_limited, out_data.steer_limited);
                check_field("engaged", want.engaged, out_data.engaged);
                check_field("engaged_pulse", want.engaged_pulse, out_data.engaged_pulse);
                check_field("recovered_pulse", want.recovered_pulse, out_data.recovered_pulse);
                check_field("snap_to_zero", want.snap_to_zero, out_data.snap_to_zero);
            end
        end
    end

    // Reset register values: limits at and past the edge, timeout boundary, snap and recovery
    task automatic test_reset_defaults();
        send_cmd(0, 0);
        send_cmd(512, 128);
        send_cmd(513, -129);
        send_cmd(-32768, 32767);
        send_tick(100, 500);
        send_tick(100, 501);
        send_tick(-100, 65535);
        send_tick(2, 600);
        send_tick(-3, 600);
        send_tick(-32768, 600);
        send_tick(0, 0);
        send_tick(0, 501);
        send_cmd(32767, -32768);
        send_tick(32767, 100);
    endtask

    // Zero and full-scale registers, including writes with the unused top bit set
    task automatic test_register_extremes();
        apply_setting(0, 0, 0, 0);
        send_cmd(1, -1);
        send_cmd(0, 0);
        send_tick(0, 0);
        apply_setting(16'hFFFF, 16'hFFFF, 0, 16'hFFFF);
        send_cmd(-32768, 32767);
        send_tick(5, 65535);
        wait_quiet();
        write_reg(cwg_pkg::CFG_TIMEOUT, 16'd0);
        send_tick(0, 1);
        send_tick(-1, 1);
        send_tick(1, 3);
        wait_quiet();
        write_reg(cwg_pkg::CFG_STOP_EPS, 16'hFFFF);
        send_tick(-32767, 9);
        send_tick(32766, 9);
    endtask

    task automatic random_setting();
        apply_setting($urandom_range(1) ? $urandom_range(32767) : $urandom_range(1024),
                      $urandom_range(1) ? $urandom_range(32767) : $urandom_range(1024),
                      $urandom_range(300), $urandom_range(2000));
    endtask

    task automatic test_random_traffic(int snd_pct, int rcv_pct, int count);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        random_setting();
        for (int k = 0; k < count; k++) begin
            if (k == count / 2)
                random_setting();
            send_item(random_item());
        end
    endtask

    initial begin
        gov_cfg    = '{accel_limit: cwg_pkg::ACCEL_LIMIT_RST,
                       steer_limit: cwg_pkg::STEER_LIMIT_RST,
                       stop_speed_eps: cwg_pkg::STOP_EPS_RST,
                       timeout_ms: cwg_pkg::TIMEOUT_RST};
        guard_on   = 1'b0;
        kept_accel = 0;
        kept_steer = 0;
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_random_traffic(8, 62, 280);
        test_random_traffic(62, 8, 280);
        test_random_traffic(0, 0, 280);

        wait_quiet();
        repeat (8) @(posedge i_clk);
        if (pending_actuation.size() != 0) begin
            n_errors++;
            $display("%0t ns: %0d results never arrived", $time, pending_actuation.size());
        end
        $display("Sent %0d items over %0d register settings, checked %0d results",
                 n_items, n_settings, n_checked);
        $display("Watchdog engaged %0d, recovered %0d, snapped %0d; clamped commands %0d",
                 n_engage, n_recover, n_snap, n_clamp);
        if (n_errors == 0) begin
            $display("PASS command_watchdog_governor");
        end else begin
            $display("FAIL command_watchdog_governor");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL command_watchdog_governor");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/cwg_pkg.sv
src/cwg_cfg_regs.sv
src/cwg_gov.sv
src/command_watchdog_governor.sv
tb/tb_top.sv
